>>> rtl/core/usf_pkg.sv
// Shared types and constants for the UTF-8 script filter.
`timescale 1ns / 1ps
`default_nettype none

package usf_pkg;

    // Code point ranges that pass the filter
    localparam logic [15:0] HEB_LO       = 16'h0590;
    localparam logic [15:0] HEB_HI       = 16'h05FF;
    localparam logic [15:0] HEB_PRES_LO  = 16'hFB1D;
    localparam logic [15:0] HEB_PRES_HI  = 16'hFB4F;
    localparam logic [15:0] PUNCT_LO     = 16'h2010;
    localparam logic [15:0] PUNCT_HI     = 16'h205F;
    localparam logic [15:0] ASCII_END    = 16'h0080;
    localparam logic [15:0] DIGIT_LO     = 16'h0030;
    localparam logic [15:0] DIGIT_HI     = 16'h0039;
    localparam logic [15:0] UPPER_LO     = 16'h0041;
    localparam logic [15:0] UPPER_HI     = 16'h005A;
    localparam logic [15:0] LOWER_LO     = 16'h0061;
    localparam logic [15:0] LOWER_HI     = 16'h007A;

    // Lead byte classes
    localparam logic [7:0] LEAD2_MASK    = 8'hE0;
    localparam logic [7:0] LEAD2_CODE    = 8'hC0;
    localparam logic [7:0] LEAD3_MASK    = 8'hF0;
    localparam logic [7:0] LEAD3_CODE    = 8'hE0;

    localparam logic [1:0] PEND_NONE     = 2'd0;
    localparam logic [1:0] PEND_ONE      = 2'd1;
    localparam logic [1:0] PEND_TWO      = 2'd2;

    localparam logic [8:0] COUNT_MAX     = 9'h1FF;
    localparam logic [7:0] LIMIT_RESET   = 8'd1;

    typedef struct packed {
        logic [1:0]  pending;
        logic [15:0] partial_cp;
        logic [8:0]  letter_count;
        logic        rejected;
    } text_state_t;

    localparam text_state_t TEXT_CLEAR = '{
        pending:      PEND_NONE,
        partial_cp:   16'h0000,
        letter_count: 9'h000,
        rejected:     1'b0
    };

endpackage

`default_nettype wire

>>> rtl/core/usf_classify.sv
// Code point classifier: ASCII letter flag and allowed-script flag.
`timescale 1ns / 1ps
`default_nettype none

module usf_classify (
    input  wire logic [15:0] code_point,
    output logic             is_letter,
    output logic             is_allowed
);

    logic is_digit;
    logic is_hebrew;
    logic is_punct;

    always_comb
    begin
        is_letter = ((code_point >= usf_pkg::UPPER_LO) && (code_point <= usf_pkg::UPPER_HI)) ||
                    ((code_point >= usf_pkg::LOWER_LO) && (code_point <= usf_pkg::LOWER_HI));
        is_digit  = (code_point >= usf_pkg::DIGIT_LO) && (code_point <= usf_pkg::DIGIT_HI);
        is_hebrew = ((code_point >= usf_pkg::HEB_LO) && (code_point <= usf_pkg::HEB_HI)) ||
                    ((code_point >= usf_pkg::HEB_PRES_LO) &&
                     (code_point <= usf_pkg::HEB_PRES_HI));
        is_punct  = ((code_point < usf_pkg::ASCII_END) && !is_letter && !is_digit) ||
                    ((code_point >= usf_pkg::PUNCT_LO) && (code_point <= usf_pkg::PUNCT_HI));
        is_allowed = is_hebrew || is_digit || is_punct;
    end

endmodule

`default_nettype wire

>>> rtl/core/usf_decode.sv
// Per-word next-state logic: UTF-8 assembly, letter count and verdict.
`timescale 1ns / 1ps
`default_nettype none

module usf_decode (
    input  wire usf_pkg::text_state_t state,
    input  wire logic [7:0]           data_byte,
    input  wire logic                 has_byte,
    input  wire logic                 last_item,
    input  wire logic [7:0]           max_latin_letters,
    output usf_pkg::text_state_t      state_next,
    output logic                      text_safe
);

    usf_pkg::text_state_t after_byte;
    logic        take;
    logic [15:0] cp_cont;
    logic [15:0] cp_sel;
    logic        classify_en;
    logic        is_letter;
    logic        is_allowed;
    logic [8:0]  count_inc;

    usf_classify u_classify (
        .code_point (cp_sel),
        .is_letter  (is_letter),
        .is_allowed (is_allowed)
    );

    always_comb
    begin
        take = has_byte && !state.rejected;

        // Merge the six payload bits of a continuation byte
        if (state.pending == usf_pkg::PEND_TWO)
        begin
            cp_cont = state.partial_cp | {4'h0, data_byte[5:0], 6'h00};
        end
        else
        begin
            cp_cont = state.partial_cp | {10'h000, data_byte[5:0]};
        end

        if (state.pending != usf_pkg::PEND_NONE)
        begin
            cp_sel = cp_cont;
        end
        else
        begin
            cp_sel = {8'h00, data_byte};
        end

        classify_en = take && ((state.pending == usf_pkg::PEND_ONE) ||
                               ((state.pending == usf_pkg::PEND_NONE) && !data_byte[7]));

        if (state.letter_count != usf_pkg::COUNT_MAX)
        begin
            count_inc = state.letter_count + 9'd1;
        end
        else
        begin
            count_inc = state.letter_count;
        end

        after_byte = state;
        if (take)
        begin
            if (state.pending != usf_pkg::PEND_NONE)
            begin
                after_byte.pending = state.pending - 2'd1;
                if (state.pending == usf_pkg::PEND_ONE)
                begin
                    after_byte.partial_cp = 16'h0000;
                end
                else
                begin
                    after_byte.partial_cp = cp_cont;
                end
            end
            else if (!data_byte[7])
            begin
                after_byte.partial_cp = state.partial_cp;
            end
            else if ((data_byte & usf_pkg::LEAD2_MASK) == usf_pkg::LEAD2_CODE)
            begin
                after_byte.partial_cp = {5'h00, data_byte[4:0], 6'h00};
                after_byte.pending    = usf_pkg::PEND_ONE;
            end
            else if ((data_byte & usf_pkg::LEAD3_MASK) == usf_pkg::LEAD3_CODE)
            begin
                after_byte.partial_cp = {data_byte[3:0], 12'h000};
                after_byte.pending    = usf_pkg::PEND_TWO;
            end
            else
            begin
                // four-byte lead, invalid lead or stray continuation
                after_byte.rejected = 1'b1;
            end

            if (classify_en)
            begin
                if (is_letter)
                begin
                    after_byte.letter_count = count_inc;
                    if (count_inc > {1'b0, max_latin_letters})
                    begin
                        after_byte.rejected = 1'b1;
                    end
                end
                else if (!is_allowed)
                begin
                    after_byte.rejected = 1'b1;
                end
            end
        end

        // A sequence left open at the end rejects the text
        text_safe = !(after_byte.rejected || (after_byte.pending != usf_pkg::PEND_NONE));

        if (last_item)
        begin
            state_next = usf_pkg::TEXT_CLEAR;
        end
        else
        begin
            state_next = after_byte;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/utf8_script_filter.sv
// Top level of the UTF-8 script filter: input register, text state, verdict register.
// A last word is held in the input register; its verdict then loads the verdict register.
// Throughput: one word per cycle; the input stalls only while a verdict waits on out_ready.
// The text state update (decode plus one classification) is the single per-word stage.
// Reset: rst_n low clears the word and verdict valids and the text state asynchronously.
// Reset also sets max_latin_letters to 1; the limit is kept across texts.
`timescale 1ns / 1ps
`default_nettype none

module utf8_script_filter (
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] max_latin_letters,

    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       has_byte,
    input  wire logic       last_item,

    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            text_safe
);

    // Input register: one word held for the decode stage
    logic       in_valid_reg;
    logic [7:0] data_byte_reg;
    logic       has_byte_reg;
    logic       last_item_reg;

    // Limit register and per-text state
    logic [7:0]           limit_reg;
    usf_pkg::text_state_t state_reg;
    usf_pkg::text_state_t state_next;
    logic                 verdict_next;

    // Verdict register
    logic out_valid_reg;
    logic text_safe_reg;

    logic out_free;
    logic fire;

    // User writes the limit only while the block is idle; no check here, so always take it
    assign cfg_ready = 1'b1;

    // Advance the held word when it makes no verdict or the verdict slot frees up
    assign out_free = !out_valid_reg || out_ready;
    assign fire     = in_valid_reg && (!last_item_reg || out_free);
    assign in_ready = !in_valid_reg || fire;

    usf_decode u_decode (
        .state             (state_reg),
        .data_byte         (data_byte_reg),
        .has_byte          (has_byte_reg),
        .last_item         (last_item_reg),
        .max_latin_letters (limit_reg),
        .state_next        (state_next),
        .text_safe         (verdict_next)
    );

    // Limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= usf_pkg::LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            limit_reg <= max_latin_letters;
        end
    end

    // Input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // Input payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_byte_reg <= data_byte;
            has_byte_reg  <= has_byte;
            last_item_reg <= last_item;
        end
    end

    // Text state: advance once per consumed word, clear after a verdict
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= usf_pkg::TEXT_CLEAR;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

    // Verdict valid: load on a last word, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && last_item_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Verdict payload: hold while stalled
    always_ff @(posedge clk)
    begin
        if (fire && last_item_reg)
        begin
            text_safe_reg <= verdict_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign text_safe = text_safe_reg;

endmodule

`default_nettype wire

>>> rtl/core/usf_checker.sv
// Port-level checker for the UTF-8 script filter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module usf_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       cfg_valid,
    input wire logic       cfg_ready,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       last_item,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       text_safe
);

    // Hold a stalled verdict
    a_verdict_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(text_safe))
        else $error("verdict changed or dropped while stalled");

    // Input backpressure only comes from a stalled verdict
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a stalled verdict");

    // A fresh verdict follows a last word taken through the input and verdict registers
    a_verdict_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && last_item, 2))
        else $error("verdict without a matching last word");

    // The limit register never stalls a write
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("limit write stalled");

endmodule

bind utf8_script_filter usf_checker u_usf_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .last_item         (last_item),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .text_safe         (text_safe)
);

`default_nettype wire

>>> test/utf8_script_filter_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the UTF-8 script filter: directed table, random texts, verdict check.
module utf8_script_filter_tb;

    // Timing and run length
    localparam int CLK_PERIOD       = 10;
    localparam int RESET_CYCLES     = 6;
    localparam int CYCLE_LIMIT      = 300000;
    localparam int DRAIN_CYCLES     = 6;      // margin kept after every owed verdict is home
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int PHASE_WORDS      = 180;    // five random phases, about 900 words in all

    // Code point classes the filter lets through
    localparam logic [15:0] CP_HEB_LO   = 16'h0590;
    localparam logic [15:0] CP_HEB_HI   = 16'h05FF;
    localparam logic [15:0] CP_PRES_LO  = 16'hFB1D;
    localparam logic [15:0] CP_PRES_HI  = 16'hFB4F;
    localparam logic [15:0] CP_PUNCT_LO = 16'h2010;
    localparam logic [15:0] CP_PUNCT_HI = 16'h205F;
    localparam logic [15:0] CP_ASCII_END = 16'h0080;
    localparam logic [15:0] CP_DIGIT_LO = 16'h0030;
    localparam logic [15:0] CP_DIGIT_HI = 16'h0039;
    localparam logic [15:0] CP_UPPER_LO = 16'h0041;
    localparam logic [15:0] CP_UPPER_HI = 16'h005A;
    localparam logic [15:0] CP_LOWER_LO = 16'h0061;
    localparam logic [15:0] CP_LOWER_HI = 16'h007A;

    // Lead byte classes
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;

    // Continuation bytes still owed by the current sequence
    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_ONE  = 2'd1;
    localparam logic [1:0] PEND_TWO  = 2'd2;

    localparam logic [8:0] LATIN_SAT      = 9'd511;
    localparam logic [7:0] LIMIT_AT_RESET = 8'd1;

    // Where a directed row takes its expected verdict from
    localparam bit TYPED   = 1'b1;
    localparam bit MODELED = 1'b0;

    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       last;
        bit         src;
        logic       safe;
    } dir_row_t;

    typedef struct packed {
        logic [7:0] data;
        logic       has;
    } text_word_t;

    localparam int DIR_ROWS = 27;

    // DUT ports
    logic       clk;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] max_latin_letters;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last_item;
    logic       out_valid;
    logic       out_ready;
    logic       text_safe;

    // Shadow of the filter state, advanced on every accepted word
    logic [1:0]  pend_cnt;
    logic [15:0] cp_acc;
    logic [8:0]  latin_cnt;
    logic        text_bad;
    logic [7:0]  latin_limit;

    // Verdicts owed by the DUT, oldest first
    logic        safe_verdicts_q[$];
    text_word_t  text_words_q[$];
    dir_row_t    directed_rows [0:DIR_ROWS-1];

    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_req_cnt;
    int  cycle_count;
    int  error_count;
    int  words_counted;
    int  texts_sent;
    int  verdicts_seen;
    int  safe_seen;
    int  limit_writes;
    logic want_safe;

    utf8_script_filter DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .max_latin_letters (max_latin_letters),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .data_byte         (data_byte),
        .has_byte          (has_byte),
        .last_item         (last_item),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .text_safe         (text_safe)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Abort a hung run
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d verdicts still owed", cycle_count,
                 safe_verdicts_q.size());
        $display("== FAIL ==");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic got, input logic want);
        $display("MISMATCH cycle %0d: %s: got %b, expected %b", cycle_count, what, got, want);
        error_count++;
    endtask

    // Classify one decoded code point; letters count toward the limit
    task automatic judge_code_point(input logic [15:0] cp);
        bit is_letter;
        bit is_digit;
        bit is_heb;
        bit is_punct;
        is_letter = (cp >= CP_UPPER_LO && cp <= CP_UPPER_HI) ||
                    (cp >= CP_LOWER_LO && cp <= CP_LOWER_HI);
        is_digit  = cp >= CP_DIGIT_LO && cp <= CP_DIGIT_HI;
        is_heb    = (cp >= CP_HEB_LO && cp <= CP_HEB_HI) ||
                    (cp >= CP_PRES_LO && cp <= CP_PRES_HI);
        is_punct  = (cp < CP_ASCII_END && !is_letter && !is_digit) ||
                    (cp >= CP_PUNCT_LO && cp <= CP_PUNCT_HI);
        if (is_letter)
        begin
            if (latin_cnt != LATIN_SAT)
                latin_cnt = latin_cnt + 9'd1;
            if (latin_cnt > {1'b0, latin_limit})
                text_bad = 1'b1;
        end
        else if (!is_heb && !is_digit && !is_punct)
            text_bad = 1'b1;
    endtask

    // Advance the shadow state by one word; flag a verdict on the last word of a text
    task automatic predict_word(input logic [7:0] d, input logic hb, input logic lst,
                                output bit verdict_due, output logic verdict);
        verdict_due = 1'b0;
        verdict     = 1'b0;
        if (hb && !text_bad)
        begin
            if (pend_cnt != PEND_NONE)
            begin
                cp_acc   = cp_acc | (({10'd0, d[5:0]}) << ((pend_cnt == PEND_TWO) ? 6 : 0));
                pend_cnt = pend_cnt - 2'd1;
                if (pend_cnt == PEND_NONE)
                begin
                    judge_code_point(cp_acc);
                    cp_acc = 16'h0000;
                end
            end
            else if (d < CP_ASCII_END[7:0] || d[7] == 1'b0)
                judge_code_point({8'h00, d});
            else if ((d & LEAD2_MASK) == LEAD2_CODE)
            begin
                cp_acc   = {5'd0, d[4:0], 6'd0};
                pend_cnt = PEND_ONE;
            end
            else if ((d & LEAD3_MASK) == LEAD3_CODE)
            begin
                cp_acc   = {d[3:0], 12'd0};
                pend_cnt = PEND_TWO;
            end
            else
                text_bad = 1'b1;
        end
        if (lst)
        begin
            // a sequence cut off by the end of the text rejects it
            if (pend_cnt != PEND_NONE)
                text_bad = 1'b1;
            verdict_due = 1'b1;
            verdict     = ~text_bad;
            pend_cnt    = PEND_NONE;
            cp_acc      = 16'h0000;
            latin_cnt   = 9'd0;
            text_bad    = 1'b0;
        end
    endtask

    // Offer one word, hold it until accepted, then book its verdict
    task automatic send_word(input logic [7:0] d, input logic hb, input logic lst,
                             input bit src, input logic typed_safe);
        bit   due;
        logic v;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= d;
        has_byte  <= hb;
        last_item <= lst;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        predict_word(d, hb, lst, due, v);
        if (hb || lst)
            words_counted++;
        if (due)
        begin
            safe_verdicts_q.push_back((src == TYPED) ? typed_safe : v);
            texts_sent++;
        end
    endtask

    // Drop valid and wait until every owed verdict has come back
    task automatic wait_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (safe_verdicts_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Only called while the DUT is idle
    task automatic write_limit(input logic [7:0] value);
        @(negedge clk);
        cfg_valid         <= 1'b1;
        max_latin_letters <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        latin_limit = value;
        limit_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Continuation byte; now and then scramble the top two bits, which the DUT ignores
    function automatic logic [7:0] cont_byte(input logic [5:0] bits6);
        logic [1:0] top;
        top = ($urandom_range(99) < 20) ? 2'($urandom_range(3)) : 2'b10;
        return {top, bits6};
    endfunction

    task automatic push_byte(input logic [7:0] d);
        text_words_q.push_back('{data: d, has: 1'b1});
    endtask

    task automatic push_cp2(input logic [15:0] cp);
        push_byte({3'b110, cp[10:6]});
        push_byte(cont_byte(cp[5:0]));
    endtask

    task automatic push_cp3(input logic [15:0] cp);
        push_byte({4'b1110, cp[15:12]});
        push_byte(cont_byte(cp[11:6]));
        push_byte(cont_byte(cp[5:0]));
    endtask

    // Build one random text, mostly well formed, then send it word by word
    task automatic send_random_text();
        int  n;
        int  i;
        int  pick;
        bit  split_end;
        text_word_t w;
        text_words_q = {};
        n = ($urandom_range(99) < 3) ? 0 : $urandom_range(1, 8);
        for (i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 18)
                push_byte(($urandom_range(1) != 0) ? 8'($urandom_range(8'h41, 8'h5A))
                                                   : 8'($urandom_range(8'h61, 8'h7A)));
            else if (pick < 30)
                push_byte(8'($urandom_range(8'h30, 8'h39)));
            else if (pick < 42)
                push_byte(8'($urandom_range(8'h00, 8'h7F)));
            else if (pick < 57)
                push_cp2(16'($urandom_range(CP_HEB_LO, CP_HEB_HI)));
            else if (pick < 67)
                push_cp3(16'($urandom_range(CP_PRES_LO, CP_PRES_HI)));
            else if (pick < 77)
                push_cp3(16'($urandom_range(CP_PUNCT_LO, CP_PUNCT_HI)));
            else if (pick < 82)
                push_cp2(16'($urandom_range(16'h0000, 16'h07FF)));
            else if (pick < 86)
                push_cp3(16'($urandom_range(16'h0000, 16'hFFFF)));
            else if (pick < 88)
                push_byte(8'($urandom_range(8'hF0, 8'hFF)));      // four-byte or bad lead
            else if (pick < 90)
                push_byte(8'($urandom_range(8'h80, 8'hBF)));      // stray continuation
            else if (pick < 92)
                push_byte(($urandom_range(1) != 0) ? 8'($urandom_range(8'hC0, 8'hDF))
                                                   : 8'($urandom_range(8'hE0, 8'hEF)));
            else if (pick < 96)
                text_words_q.push_back('{data: 8'($urandom_range(255)), has: 1'b0});
            else
                push_byte(8'($urandom_range(255)));
        end
        split_end = (text_words_q.size() == 0) || ($urandom_range(99) < 15);
        while (text_words_q.size() != 0)
        begin
            w = text_words_q.pop_front();
            send_word(w.data, w.has, !split_end && text_words_q.size() == 0, MODELED, 1'b0);
        end
        if (split_end)
            send_word(8'($urandom_range(255)), 1'b0, 1'b1, MODELED, 1'b0);
    endtask

    // One random phase: set the limit while idle, pick the idling mix, then stream texts.
    // With a long hold, the receiver backs off while texts keep coming, and halfway
    // the sender pauses until every verdict is home.
    task automatic run_phase(input logic [7:0] limit, input int idle_pct,
                             input int stall_pct, input bit long_hold);
        int start_words;
        bit paused;
        wait_drain();
        write_limit(limit);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        if (long_hold)
            hold_req_cnt++;
        start_words = words_counted;
        paused      = 1'b0;
        while (words_counted - start_words < PHASE_WORDS)
        begin
            send_random_text();
            if (long_hold && !paused && words_counted - start_words >= PHASE_WORDS / 2)
            begin
                wait_drain();
                paused = 1'b1;
            end
        end
    endtask

    // Receiver: random stalls, and a long hold-off on request
    initial
    begin : receiver
        int hold_left;
        int hold_done_cnt;
        hold_left     = 0;
        hold_done_cnt = 0;
        out_ready     = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left != 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (hold_req_cnt != hold_done_cnt)
            begin
                out_ready <= 1'b0;
                hold_left = LONG_HOLD_CYCLES - 1;
                hold_done_cnt++;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each verdict with the oldest one owed
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (safe_verdicts_q.size() == 0)
                report_mismatch("verdict with none owed", text_safe, 1'bx);
            else
            begin
                want_safe = safe_verdicts_q.pop_front();
                if (text_safe !== want_safe)
                    report_mismatch("text_safe", text_safe, want_safe);
                verdicts_seen++;
                if (text_safe === 1'b1)
                    safe_seen++;
            end
        end
    end

    // Stimulus
    initial
    begin : stimulus
        int r;
        rst_n             = 1'b0;
        cfg_valid         = 1'b0;
        max_latin_letters = 8'h00;
        in_valid          = 1'b0;
        data_byte         = 8'h00;
        has_byte          = 1'b0;
        last_item         = 1'b0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        hold_req_cnt      = 0;
        cycle_count       = 0;
        error_count       = 0;
        words_counted     = 0;
        texts_sent        = 0;
        verdicts_seen     = 0;
        safe_seen         = 0;
        limit_writes      = 0;
        pend_cnt          = PEND_NONE;
        cp_acc            = 16'h0000;
        latin_cnt         = 9'd0;
        text_bad          = 1'b0;
        latin_limit       = LIMIT_AT_RESET;

        // Directed rows run under the reset limit of one letter
        directed_rows = '{
            '{8'h00, 1'b0, 1'b1, TYPED,   1'b1},   // empty text is safe
            '{8'h41, 1'b1, 1'b1, TYPED,   1'b1},   // one letter fits the limit
            '{8'h7A, 1'b1, 1'b0, MODELED, 1'b0},
            '{8'h5A, 1'b1, 1'b1, TYPED,   1'b0},   // second letter goes over
            '{8'h00, 1'b1, 1'b0, MODELED, 1'b0},
            '{8'h7F, 1'b1, 1'b0, MODELED, 1'b0},
            '{8'h39, 1'b1, 1'b1, MODELED, 1'b0},
            '{8'hD6, 1'b1, 1'b0, MODELED, 1'b0},   // lowest Hebrew
            '{8'h90, 1'b1, 1'b0, MODELED, 1'b0},
            '{8'hA5, 1'b0, 1'b0, MODELED, 1'b0},   // word with no byte, no effect
            '{8'hD7, 1'b1, 1'b0, MODELED, 1'b0},   // highest Hebrew
            '{8'hBF, 1'b1, 1'b1, MODELED, 1'b0},
            '{8'hEF, 1'b1, 1'b0, MODELED, 1'b0},   // lowest presentation form
            '{8'hAC, 1'b1, 1'b0, MODELED, 1'b0},
            '{8'h9D, 1'b1, 1'b0, MODELED, 1'b0},
            '{8'hE2, 1'b1, 1'b0, MODELED, 1'b0},   // top of general punctuation
            '{8'h81, 1'b1, 1'b0, MODELED, 1'b0},
            '{8'h9F, 1'b1, 1'b1, MODELED, 1'b0},
            '{8'hFF, 1'b1, 1'b0, TYPED,   1'b0},   // bad lead, rest ignored
            '{8'h41, 1'b1, 1'b1, TYPED,   1'b0},
            '{8'hBF, 1'b1, 1'b1, TYPED,   1'b0},   // stray continuation
            '{8'hE2, 1'b1, 1'b0, MODELED, 1'b0},   // cut off at the end
            '{8'h80, 1'b1, 1'b1, TYPED,   1'b0},
            '{8'hC3, 1'b1, 1'b0, MODELED, 1'b0},   // Latin-1 letter, outside the set
            '{8'hA9, 1'b1, 1'b1, TYPED,   1'b0},
            '{8'hD6, 1'b1, 1'b0, MODELED, 1'b0},   // plain byte taken as continuation
            '{8'h10, 1'b1, 1'b1, MODELED, 1'b0}
        };

        // Hold reset, then release it on a falling edge
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (r = 0; r < DIR_ROWS; r++)
            send_word(directed_rows[r].data, directed_rows[r].has, directed_rows[r].last,
                      directed_rows[r].src, directed_rows[r].safe);

        // Random phases: extremes of the limit first, then small limits, then a random one
        run_phase(8'd0,   0,  0,  1'b0);
        run_phase(8'd255, 60, 0,  1'b0);
        run_phase(8'($urandom_range(1, 6)), 0, 60, 1'b0);
        run_phase(8'd2,   25, 25, 1'b0);
        run_phase(8'($urandom_range(0, 255)), 0, 0, 1'b1);

        // Drain, let the pipeline settle, then report
        wait_drain();
        $display("Ran %0d words in %0d texts, %0d verdicts back (%0d safe), %0d limit writes.",
                 words_counted, texts_sent, verdicts_seen, safe_seen, limit_writes);
        $display("Idling mixes: none, sender 60%%, receiver 60%%, both 25%%, plus a long hold.");
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
